@@ rtl/kfi_pkg.sv @@
// ----------------------------------------------------------------------------
// kfi_pkg: shared types and constants of the keyframe interpolator
// Table geometry, request and status codes, table entry and lane request.
// ----------------------------------------------------------------------------
package kfi_pkg;

	localparam int MAX_POINTS   = 64;
	localparam int NUM_CHANNELS = 4;
	localparam int ADDR_W       = $clog2(MAX_POINTS);
	localparam int CNT_W        = $clog2(MAX_POINTS + 1);
	localparam int VAL_W        = 32;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_EVAL   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

	typedef struct packed {
		logic [NUM_CHANNELS-1:0][VAL_W-1:0] vals;
		logic                               kind;
		logic [VAL_W-1:0]                   frame;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] vl;
		logic [VAL_W-1:0] vr;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
		logic [VAL_W-1:0] d;
	} lane_req_t;

endpackage

@@ rtl/kfi_ram.sv @@
// ----------------------------------------------------------------------------
// kfi_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/kfi_lane.sv @@
// ----------------------------------------------------------------------------
// kfi_lane: one interpolation channel
// Forms the weighted sum of the two end values and divides it by the frame
// span one quotient bit per cycle, truncating toward zero and saturating.
// ----------------------------------------------------------------------------
module kfi_lane import kfi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lane_req_t        req,
	output logic             done,
	output logic [VAL_W-1:0] result
);

	typedef enum logic [1:0] {
		L_IDLE,
		L_MUL,
		L_SUM,
		L_DIV
	} lstate_t;

	lstate_t          state_q;
	logic             done_q;
	logic [VAL_W-1:0] vl_q, vr_q, a_q, b_q, d_q;
	logic [63:0]      pa_q, pb_q;
	logic [63:0]      quo_q;
	logic [VAL_W-1:0] rem_q;
	logic             neg_q;
	logic [5:0]       step_q;

	logic signed [64:0] pa_full, pb_full;
	logic [63:0]        num;
	logic [VAL_W:0]     trial;
	logic               take;
	logic signed [63:0] sq;

	assign pa_full = $signed(vr_q) * $signed({1'b0, a_q});
	assign pb_full = $signed(vl_q) * $signed({1'b0, b_q});
	assign num     = pa_q + pb_q;
	assign trial   = {rem_q, quo_q[63]};
	assign take    = trial >= {1'b0, d_q};
	assign sq      = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_comb begin
		if (sq > 64'sd2147483647) begin
			result = 32'h7FFF_FFFF;
		end else if (sq < -64'sd2147483648) begin
			result = 32'h8000_0000;
		end else begin
			result = sq[VAL_W-1:0];
		end
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (req.start) begin
						vl_q    <= req.vl;
						vr_q    <= req.vr;
						a_q     <= req.a;
						b_q     <= req.b;
						d_q     <= req.d;
						done_q  <= 1'b0;
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					pa_q    <= pa_full[63:0];
					pb_q    <= pb_full[63:0];
					state_q <= L_SUM;
				end
				L_SUM: begin
					neg_q   <= num[63];
					quo_q   <= num[63] ? -num : num;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= L_DIV;
				end
				L_DIV: begin
					rem_q  <= take ? VAL_W'(trial - {1'b0, d_q}) : trial[VAL_W-1:0];
					quo_q  <= {quo_q[62:0], take};
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63) begin
						done_q  <= 1'b1;
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/keyframe_interpolator.sv @@
// ----------------------------------------------------------------------------
// keyframe_interpolator: sorted keyframe table with four-channel interpolation
// Add, remove and evaluate requests against a table of up to 64 keyframes.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives exactly one response. The
// table lives in a RAM with a single read port, so an add reads each entry at
// or before the new frame and then moves the later entries up one by one, a
// remove moves the later entries down one by one, and an evaluate scans the
// entries and, on a linear segment, runs four divider lanes side by side.
// A new request is taken while the previous response still waits on the output.
module keyframe_interpolator import kfi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// frame, point_kind, value_0, value_1, value_2, value_3, position, zero pad
	input  logic [167:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_0, out_1, out_2, out_3, point_count, zero pad
	output logic [135:0] m_tdata,
	// status
	output logic [1:0]   m_tuser
);

	typedef enum logic [3:0] {
		IDLE,
		A_SCAN_RD,
		A_SCAN_CHK,
		A_SHIFT,
		A_SHIFT_WR,
		R_SHIFT,
		R_WR,
		E_SCAN_RD,
		E_SCAN_CHK,
		E_PICK,
		E_LEFT,
		E_RIGHT,
		E_DIV,
		FINISH
	} state_t;

	state_t                             state_q;
	entry_t                             new_q;
	entry_t                             lft_q;
	logic [CNT_W-1:0]                   pos_q, cnt_q, j_q, k_q;
	logic [ADDR_W-1:0]                  left_q;
	logic                               found_q;
	status_t                            status_q;
	logic [NUM_CHANNELS-1:0][VAL_W-1:0] res_q;
	logic                               m_tvalid_q;
	logic [135:0]                       m_tdata_q;
	logic [1:0]                         m_tuser_q;

	entry_t                             rd;
	logic [ENTRY_W-1:0]                 rdata;
	logic [ENTRY_W-1:0]                 wdata;
	logic                               we;
	logic [ADDR_W-1:0]                  raddr, waddr;
	logic [CNT_W-1:0]                   km1, kp1;
	logic [CNT_W-1:0]                   lp1;
	lane_req_t [NUM_CHANNELS-1:0]       lreq;
	logic [NUM_CHANNELS-1:0]            ldone;
	logic [NUM_CHANNELS-1:0][VAL_W-1:0] lres;
	logic                               accept;
	logic                               out_free;

	assign rd       = entry_t'(rdata);
	assign km1      = k_q - CNT_W'(1);
	assign kp1      = k_q + CNT_W'(1);
	assign lp1      = {1'b0, left_q} + CNT_W'(1);
	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = k_q[ADDR_W-1:0];
		wdata = rdata;
		case (state_q)
			A_SCAN_RD:  raddr = j_q[ADDR_W-1:0];
			E_SCAN_RD:  raddr = j_q[ADDR_W-1:0];
			A_SHIFT: begin
				raddr = km1[ADDR_W-1:0];
				if (k_q == pos_q) begin
					we    = 1'b1;
					waddr = pos_q[ADDR_W-1:0];
					wdata = new_q;
				end
			end
			A_SHIFT_WR: we = 1'b1;
			R_SHIFT:    raddr = kp1[ADDR_W-1:0];
			R_WR:       we = 1'b1;
			E_PICK:     raddr = found_q ? left_q : '0;
			E_LEFT:     raddr = lp1[ADDR_W-1:0];
			default:    raddr = '0;
		endcase
	end

	kfi_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
		assign lreq[c].start = (state_q == E_RIGHT);
		assign lreq[c].vl    = lft_q.vals[c];
		assign lreq[c].vr    = rd.vals[c];
		assign lreq[c].a     = new_q.frame - lft_q.frame;
		assign lreq[c].b     = rd.frame - new_q.frame;
		assign lreq[c].d     = rd.frame - lft_q.frame;

		kfi_lane u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.req   (lreq[c]),
			.done  (ldone[c]),
			.result(lres[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						new_q.frame <= s_tdata[31:0];
						new_q.kind  <= s_tdata[32];
						new_q.vals  <= s_tdata[160:33];
						pos_q       <= {1'b0, s_tdata[166:161]};
						status_q    <= ST_OK;
						res_q       <= '0;
						j_q         <= '0;
						found_q     <= 1'b0;
						left_q      <= '0;
						state_q     <= FINISH;
						case (req_t'(s_tuser))
							REQ_ADD: begin
								if (cnt_q >= CNT_W'(MAX_POINTS)) begin
									status_q <= ST_FULL;
								end else begin
									state_q <= A_SCAN_RD;
								end
							end
							REQ_REMOVE: begin
								if ({1'b0, s_tdata[166:161]} >= cnt_q) begin
									status_q <= ST_RANGE;
								end else begin
									k_q     <= {1'b0, s_tdata[166:161]};
									state_q <= R_SHIFT;
								end
							end
							REQ_EVAL: begin
								if (cnt_q != '0) begin
									state_q <= E_SCAN_RD;
								end
							end
							default: state_q <= FINISH;
						endcase
					end
				end
				A_SCAN_RD: begin
					if (j_q == cnt_q) begin
						pos_q   <= j_q;
						k_q     <= cnt_q;
						state_q <= A_SHIFT;
					end else begin
						state_q <= A_SCAN_CHK;
					end
				end
				A_SCAN_CHK: begin
					if ($signed(rd.frame) <= $signed(new_q.frame)) begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= A_SCAN_RD;
					end else begin
						pos_q   <= j_q;
						k_q     <= cnt_q;
						state_q <= A_SHIFT;
					end
				end
				A_SHIFT: begin
					if (k_q == pos_q) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= FINISH;
					end else begin
						state_q <= A_SHIFT_WR;
					end
				end
				A_SHIFT_WR: begin
					k_q     <= km1;
					state_q <= A_SHIFT;
				end
				R_SHIFT: begin
					if (kp1 >= cnt_q) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= FINISH;
					end else begin
						state_q <= R_WR;
					end
				end
				R_WR: begin
					k_q     <= kp1;
					state_q <= R_SHIFT;
				end
				E_SCAN_RD: begin
					state_q <= (j_q == cnt_q) ? E_PICK : E_SCAN_CHK;
				end
				E_SCAN_CHK: begin
					if ($signed(rd.frame) <= $signed(new_q.frame)) begin
						found_q <= 1'b1;
						left_q  <= j_q[ADDR_W-1:0];
						j_q     <= j_q + CNT_W'(1);
						state_q <= E_SCAN_RD;
					end else begin
						state_q <= E_PICK;
					end
				end
				E_PICK: state_q <= E_LEFT;
				E_LEFT: begin
					if (!found_q || lp1 >= cnt_q || !rd.kind) begin
						res_q   <= rd.vals;
						state_q <= FINISH;
					end else begin
						lft_q   <= rd;
						state_q <= E_RIGHT;
					end
				end
				E_RIGHT: state_q <= E_DIV;
				E_DIV: begin
					if (&ldone) begin
						res_q   <= lres;
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						m_tdata_q  <= {1'b0, cnt_q, res_q};
						m_tuser_q  <= status_q;
						state_q    <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

@@ rtl/kfi_checker.sv @@
// ----------------------------------------------------------------------------
// kfi_checker: port-level checks of the keyframe interpolator
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
module kfi_checker import kfi_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata,
	input logic [1:0]   m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled response changed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[134:128] <= 7'(MAX_POINTS))
		else $error("point count above table size");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> m_tdata[134:128] == 7'(MAX_POINTS))
		else $error("full status with room left");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[127:0] == '0)
		else $error("failed request carried channel data");

endmodule

bind keyframe_interpolator kfi_checker u_kfi_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

@@ verif/keyframe_interpolator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_interpolator_tb: self-checking bench for the keyframe interpolator
// Streams add, remove and evaluate requests through a bursty driver, predicts
// each response from a software copy of the keyframe table, and compares the
// responses field by field under random and long output stalls.
// ----------------------------------------------------------------------------
module keyframe_interpolator_tb;
	import kfi_pkg::*;

	typedef struct {
		req_t              req;
		logic signed [31:0] frame;
		logic              kind;
		logic signed [31:0] val [4];
		logic [5:0]        position;
	} request_t;

	typedef struct {
		logic signed [31:0] outv [4];
		status_t            status;
		logic [6:0]         count;
	} response_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [167:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic [1:0]   m_tuser;

	request_t  pending_requests [$];
	response_t expected_responses [$];

	logic signed [31:0] tbl_frame [64];
	logic               tbl_kind [64];
	logic signed [31:0] tbl_val [64][4];
	int                 tbl_count;

	int  mismatches;
	int  responses_seen;
	int  cycles;
	int  burst_left;
	int  gap_left;
	int  hold_off;
	int  stall_phase;
	bit  long_stall_req;
	bit  sender_pause;

	keyframe_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic response_t predict_response(request_t r);
		response_t rsp;
		int pos;
		int lft;
		logic signed [63:0] a, b, d, num, quo;
		for (int j = 0; j < 4; j++) rsp.outv[j] = '0;
		rsp.status = ST_OK;
		case (r.req)
			REQ_ADD: begin
				if (tbl_count >= MAX_POINTS) begin
					rsp.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < tbl_count && tbl_frame[pos] <= r.frame) pos++;
					for (int k = tbl_count; k > pos; k--) begin
						tbl_frame[k] = tbl_frame[k-1];
						tbl_kind[k]  = tbl_kind[k-1];
						for (int j = 0; j < 4; j++) tbl_val[k][j] = tbl_val[k-1][j];
					end
					tbl_frame[pos] = r.frame;
					tbl_kind[pos]  = r.kind;
					for (int j = 0; j < 4; j++) tbl_val[pos][j] = r.val[j];
					tbl_count++;
				end
			end
			REQ_REMOVE: begin
				if (r.position >= tbl_count) begin
					rsp.status = ST_RANGE;
				end else begin
					for (int k = r.position; k + 1 < tbl_count; k++) begin
						tbl_frame[k] = tbl_frame[k+1];
						tbl_kind[k]  = tbl_kind[k+1];
						for (int j = 0; j < 4; j++) tbl_val[k][j] = tbl_val[k+1][j];
					end
					tbl_count--;
				end
			end
			REQ_EVAL: begin
				if (tbl_count > 0) begin
					lft = -1;
					for (int k = 0; k < tbl_count; k++) begin
						if (tbl_frame[k] <= r.frame) lft = k;
						else break;
					end
					if (lft < 0) begin
						for (int j = 0; j < 4; j++) rsp.outv[j] = tbl_val[0][j];
					end else if (lft + 1 >= tbl_count || !tbl_kind[lft]) begin
						for (int j = 0; j < 4; j++) rsp.outv[j] = tbl_val[lft][j];
					end else begin
						a = 64'(r.frame) - 64'(tbl_frame[lft]);
						b = 64'(tbl_frame[lft+1]) - 64'(r.frame);
						d = 64'(tbl_frame[lft+1]) - 64'(tbl_frame[lft]);
						if (d <= 0) d = 1;
						for (int j = 0; j < 4; j++) begin
							num = 64'(tbl_val[lft+1][j]) * a + 64'(tbl_val[lft][j]) * b;
							quo = num / d;
							if (quo > 64'sd2147483647) quo = 64'sd2147483647;
							if (quo < -64'sd2147483648) quo = -64'sd2147483648;
							rsp.outv[j] = quo[31:0];
						end
					end
				end
			end
			default: ;
		endcase
		rsp.count = 7'(tbl_count);
		return rsp;
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom_range(0, 200)) - 100;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_request(req_t rq, logic signed [31:0] f, logic k,
			logic signed [31:0] v0, logic signed [31:0] v1,
			logic signed [31:0] v2, logic signed [31:0] v3, logic [5:0] p);
		request_t r;
		r.req = rq; r.frame = f; r.kind = k; r.position = p;
		r.val[0] = v0; r.val[1] = v1; r.val[2] = v2; r.val[3] = v3;
		pending_requests.push_back(r);
	endtask

	task automatic queue_random(int size_hint);
		int sel;
		logic signed [31:0] f;
		sel = $urandom_range(0, 99);
		if (size_hint < 64 && $urandom_range(0, 3) == 0) f = $urandom_range(0, 40) << 16;
		else f = rand_word();
		if (sel < 40)
			queue_request(REQ_ADD, f, $urandom_range(0, 1), rand_word(), rand_word(),
				rand_word(), rand_word(), $urandom);
		else if (sel < 55)
			queue_request(REQ_REMOVE, $urandom, $urandom_range(0, 1), $urandom, $urandom,
				$urandom, $urandom, $urandom_range(0, 20) == 0 ? $urandom : $urandom_range(0, 12));
		else if (sel < 97)
			queue_request(REQ_EVAL, f, $urandom_range(0, 1), $urandom, $urandom,
				$urandom, $urandom, $urandom);
		else
			queue_request(REQ_NONE, $urandom, $urandom_range(0, 1), $urandom, $urandom,
				$urandom, $urandom, $urandom);
	endtask

	// Sender: bursts and gaps, plus a pause until the output side has drained.
	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				r = pending_requests.pop_front();
				expected_responses.push_back(predict_response(r));
			end
			if (sender_pause && expected_responses.size() != 0) begin
				s_tvalid <= 1'b0;
			end else if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_requests.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				r = pending_requests[0];
				s_tvalid <= 1'b1;
				s_tuser  <= r.req;
				s_tdata  <= {1'b0, r.position, r.val[3], r.val[2], r.val[1], r.val[0],
					r.kind, r.frame};
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 12);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 60);
				end
			end
		end
	end

	// Receiver: its own stall pattern, and a long hold-off when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			hold_off    <= 0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (long_stall_req && hold_off == 0) begin
				hold_off <= 3000;
				m_tready <= 1'b0;
			end else if (hold_off > 1) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else begin
				if (hold_off == 1) hold_off <= 0;
				case ((stall_phase / 500) % 3)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= (stall_phase % 7) < 2;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		response_t exp_rsp;
		logic signed [31:0] got [4];
		bit bad;
		if (arst_n && m_tvalid && m_tready) begin
			responses_seen++;
			for (int j = 0; j < 4; j++) got[j] = m_tdata[32*j +: 32];
			if (expected_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %h", m_tdata);
			end else begin
				exp_rsp = expected_responses.pop_front();
				bad = (m_tuser != exp_rsp.status) || (m_tdata[134:128] != exp_rsp.count)
					|| (m_tdata[135] !== 1'b0);
				for (int j = 0; j < 4; j++) bad |= (got[j] !== exp_rsp.outv[j]);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: expected %h %h %h %h st %0d n %0d, got %h %h %h %h st %0d n %0d",
							responses_seen, exp_rsp.outv[0], exp_rsp.outv[1], exp_rsp.outv[2],
							exp_rsp.outv[3], exp_rsp.status, exp_rsp.count, got[0], got[1],
							got[2], got[3], m_tuser, m_tdata[134:128]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 1500000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int adds;
		arst_n         = 1'b0;
		mismatches     = 0;
		responses_seen = 0;
		cycles         = 0;
		long_stall_req = 1'b0;
		sender_pause   = 1'b0;
		tbl_count      = 0;

		// Directed: empty table, extremes, equal frames, hold and linear segments.
		queue_request(REQ_EVAL, 32'sh0, 1'b0, 0, 0, 0, 0, 0);
		queue_request(REQ_REMOVE, 32'sh0, 1'b0, 0, 0, 0, 0, 6'd0);
		queue_request(REQ_NONE, 32'shffffffff, 1'b1, -1, -1, -1, -1, 6'h3f);
		queue_request(REQ_ADD, 32'sh00100000, 1'b1, 32'sh7fffffff, 32'sh80000000, 0, -1, 0);
		queue_request(REQ_ADD, 32'sh00200000, 1'b0, 32'sh80000000, 32'sh7fffffff, 100, 1, 6'h3f);
		queue_request(REQ_ADD, 32'sh00200000, 1'b1, 5, 6, 7, 8, 0);
		queue_request(REQ_ADD, 32'sh7fffffff, 1'b0, 9, 9, 9, 9, 0);
		queue_request(REQ_ADD, 32'sh80000000, 1'b1, -7, 7, 32'sh7fffffff, 32'sh80000000, 0);
		queue_request(REQ_EVAL, 32'sh80000000, 1'b0, 0, 0, 0, 0, 0);
		queue_request(REQ_EVAL, 32'sh00000000, 1'b0, 0, 0, 0, 0, 0);
		queue_request(REQ_EVAL, 32'sh00180000, 1'b0, 0, 0, 0, 0, 0);
		queue_request(REQ_EVAL, 32'sh0010ffff, 1'b0, 0, 0, 0, 0, 0);
		queue_request(REQ_EVAL, 32'sh00200000, 1'b0, 0, 0, 0, 0, 0);
		queue_request(REQ_EVAL, 32'sh00280000, 1'b0, 0, 0, 0, 0, 0);
		queue_request(REQ_EVAL, 32'sh7fffffff, 1'b0, 0, 0, 0, 0, 0);
		queue_request(REQ_EVAL, 32'sh000fffff, 1'b0, 0, 0, 0, 0, 0);
		queue_request(REQ_REMOVE, 0, 1'b0, 0, 0, 0, 0, 6'd5);
		queue_request(REQ_REMOVE, 0, 1'b0, 0, 0, 0, 0, 6'd4);
		queue_request(REQ_REMOVE, 0, 1'b0, 0, 0, 0, 0, 6'd0);
		queue_request(REQ_EVAL, 32'sh00180000, 1'b0, 0, 0, 0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Hold off the output, then fill the table past its capacity.
		long_stall_req <= 1'b1;
		@(posedge clk);
		long_stall_req <= 1'b0;
		for (adds = 0; adds < 70; adds++)
			queue_request(REQ_ADD, rand_word(), $urandom_range(0, 1), rand_word(), rand_word(),
				rand_word(), rand_word(), $urandom);
		for (int i = 0; i < 60; i++) queue_random(64);
		for (int i = 0; i < 64; i++)
			queue_request(REQ_REMOVE, 0, 1'b0, 0, 0, 0, 0, $urandom_range(0, 63));
		wait (pending_requests.size() == 0);

		sender_pause = 1'b1;
		wait (expected_responses.size() == 0);
		@(posedge clk);
		sender_pause = 1'b0;

		for (int i = 0; i < 420; i++) queue_random(i % 100 < 60 ? 10 : 64);
		wait (pending_requests.size() == 0);
		wait (expected_responses.size() == 0);
		repeat (200) @(posedge clk);

		$display("Covered %0d responses: full and empty table, equal frames, hold and",
			responses_seen);
		$display("linear segments at extreme frames and values, bad positions, stalls.");
		if (mismatches == 0 && expected_responses.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/kfi_pkg.sv
rtl/kfi_ram.sv
rtl/kfi_lane.sv
rtl/keyframe_interpolator.sv
rtl/kfi_checker.sv
verif/keyframe_interpolator_tb.sv
